// ----- rtl/wrst_pkg.sv -----
// Weighted random select tree: shared types and constants.
// Used by the controller, datapath, top level and checker; no dependencies.
package wrst_pkg;

	localparam int WGT_W = 16;
	localparam int SUM_W = 24;
	localparam int RND_W = 31;
	localparam int IDX_W = 9;

	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_DELETE = 2'd1,
		FN_SELECT = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_BAD   = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]       func;
		logic [WGT_W-1:0] new_weight;
		logic [IDX_W-1:0] slot_index;
		logic [RND_W-1:0] random_word;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] chosen_slot;
		logic [SUM_W-1:0] total_weight;
		logic [IDX_W-1:0] occupancy;
	} out_beat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_DISPATCH,
		S_A_RDNEXT,
		S_A_WAIT,
		S_A_SETUP,
		S_P_RD,
		S_P_WAIT,
		S_P_WR,
		S_D_RD,
		S_D_WAIT,
		S_D_SETUP,
		S_M_STEP,
		S_W_RD,
		S_W_WAIT,
		S_W_DEC,
		S_DONE
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic init_wr;
		logic a_rdnext;
		logic a_setup;
		logic p_rd;
		logic p_wr;
		logic d_rd;
		logic d_setup;
		logic m_step;
		logic w_rd;
		logic w_dec;
		logic finish_st;
		logic [1:0] st;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic init_last;
		logic full;
		logic del_bad;
		logic empty;
		logic p_last;
		logic m_last;
		logic w_done;
	} sts_t;

endpackage

// ----- rtl/wrst_ram.sv -----
// Generic single-port write, single read RAM with registered read.
// No dependencies.
module wrst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/wrst_dp.sv -----
// Weighted random select tree datapath: slot memories, valid bits, free list,
// serial modulo and tree walk registers. Depends on wrst_pkg and wrst_ram.
module wrst_dp import wrst_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_beat,
	input  cmd_t      cmd,
	output sts_t      sts,
	output out_beat_t res
);
	localparam int AW = $clog2(SLOTS);
	localparam int NW = $clog2(SLOTS + 1);
	localparam int MW = 32;

	in_beat_t           req_q;
	logic [NW-1:0]      free_head_q, used_q, node_q, init_q;
	logic [SLOTS-1:0]   valid_q;
	logic [WGT_W-1:0]   wgt_q;
	logic               sub_q;
	logic [SUM_W-1:0]   total_q;
	logic [SUM_W-1:0]   rem_q, w_q;
	logic [RND_W-1:0]   dvd_q;
	logic [5:0]         mcnt_q;
	logic [NW-1:0]      chosen_q;
	logic [1:0]         st_q;

	// memories: weight, subtree sum and free_next, each with its own address
	logic               sw_we, ss_we, fn_we;
	logic [AW-1:0]      sw_wa, ss_wa, fn_wa, sw_ra, ss_ra, fn_ra;
	logic [WGT_W-1:0]   sw_wd, sw_rd;
	logic [SUM_W-1:0]   ss_wd, ss_rd;
	logic [NW-1:0]      fn_wd, fn_rd;

	wrst_ram #(.WIDTH(WGT_W), .DEPTH(SLOTS)) u_sw (.clk, .we(sw_we), .waddr(sw_wa),
		.wdata(sw_wd), .raddr(sw_ra), .rdata(sw_rd));
	wrst_ram #(.WIDTH(SUM_W), .DEPTH(SLOTS)) u_ss (.clk, .we(ss_we), .waddr(ss_wa),
		.wdata(ss_wd), .raddr(ss_ra), .rdata(ss_rd));
	wrst_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_fn (.clk, .we(fn_we), .waddr(fn_wa),
		.wdata(fn_wd), .raddr(fn_ra), .rdata(fn_rd));

	logic [NW-1:0] nm1, left_n;
	logic          left_in;
	logic [MW-1:0] trial;
	logic [SUM_W:0] rsh;

	always_comb begin
		nm1     = node_q - NW'(1);
		left_n  = {node_q[NW-2:0], 1'b0};
		left_in = (node_q <= NW'(SLOTS / 2));
		rsh     = {rem_q, dvd_q[RND_W-1]};
		trial   = MW'(rsh) - MW'(total_q);
	end

	// left child sum read in W_RD stage captured in w wait; we use two reads
	logic [SUM_W-1:0] lsum_q;
	logic             rd_left_q;

	always_comb begin
		sw_we = 1'b0; ss_we = 1'b0; fn_we = 1'b0;
		sw_wa = nm1[AW-1:0]; ss_wa = nm1[AW-1:0]; fn_wa = nm1[AW-1:0];
		sw_wd = wgt_q; ss_wd = '0; fn_wd = '0;
		sw_ra = nm1[AW-1:0]; ss_ra = nm1[AW-1:0]; fn_ra = nm1[AW-1:0];
		if (cmd.init_wr) begin
			sw_we = 1'b1; ss_we = 1'b1; fn_we = 1'b1;
			sw_wa = init_q[AW-1:0]; ss_wa = init_q[AW-1:0]; fn_wa = init_q[AW-1:0];
			sw_wd = '0;
			fn_wd = (init_q == NW'(SLOTS - 1)) ? '0 : NW'(init_q + NW'(2));
		end
		if (cmd.a_rdnext) begin
			fn_ra = free_head_q[AW-1:0] - AW'(1);
		end
		if (cmd.a_setup) begin
			sw_we = 1'b1;
			sw_wa = free_head_q[AW-1:0] - AW'(1);
		end
		if (cmd.d_rd) begin
			sw_ra = req_q.slot_index[AW-1:0] - AW'(1);
		end
		if (cmd.d_setup) begin
			sw_we = 1'b1; sw_wd = '0;
			sw_wa = req_q.slot_index[AW-1:0] - AW'(1);
			fn_we = 1'b1; fn_wd = free_head_q;
			fn_wa = req_q.slot_index[AW-1:0] - AW'(1);
		end
		if (cmd.p_rd) begin
			ss_ra = nm1[AW-1:0];
		end
		if (cmd.p_wr) begin
			ss_we = 1'b1;
			ss_wd = sub_q ? ss_rd - SUM_W'(wgt_q) : ss_rd + SUM_W'(wgt_q);
		end
		if (cmd.w_rd) begin
			ss_ra = left_n[AW-1:0] - AW'(1);
		end
	end

	logic node_bad;
	assign node_bad = (node_q == '0) || (node_q > NW'(SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= NW'(1);
			used_q      <= '0;
			valid_q     <= '0;
			total_q     <= '0;
			init_q      <= '0;
			st_q        <= ST_OK;
			chosen_q    <= '0;
		end else begin
			if (cmd.init_wr) init_q <= init_q + NW'(1);
			if (cmd.load) begin
				chosen_q <= '0;
			end
			if (cmd.a_setup) begin
				free_head_q <= fn_rd;
				valid_q[free_head_q[AW-1:0] - AW'(1)] <= 1'b1;
				used_q <= used_q + NW'(1);
				total_q <= total_q + SUM_W'(wgt_q);
				chosen_q <= free_head_q;
			end
			if (cmd.d_setup) begin
				free_head_q <= req_q.slot_index[NW-1:0];
				valid_q[req_q.slot_index[AW-1:0] - AW'(1)] <= 1'b0;
				used_q <= used_q - NW'(1);
				total_q <= total_q - SUM_W'(sw_rd);
			end
			if (cmd.w_dec && sts.w_done) chosen_q <= node_q;
			if (cmd.finish_st) st_q <= cmd.st;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_beat;
			wgt_q <= in_beat.new_weight;
			sub_q <= 1'b0;
			dvd_q <= in_beat.random_word;
			rem_q <= '0;
			mcnt_q <= '0;
		end
		if (cmd.a_setup) node_q <= free_head_q;
		if (cmd.d_setup) begin
			node_q <= req_q.slot_index[NW-1:0];
			wgt_q  <= sw_rd;
			sub_q  <= 1'b1;
		end
		if (cmd.p_wr) node_q <= node_q >> 1;
		if (cmd.m_step) begin
			dvd_q  <= dvd_q << 1;
			mcnt_q <= mcnt_q + 6'd1;
			rem_q  <= trial[MW-1] ? SUM_W'(rsh) : SUM_W'(trial);
			if (mcnt_q == 6'(RND_W - 1)) node_q <= NW'(1);
		end
		if (cmd.m_step && mcnt_q == 6'(RND_W - 1)) begin
			w_q <= trial[MW-1] ? SUM_W'(rsh) : SUM_W'(trial);
		end
		if (cmd.w_rd) rd_left_q <= left_in;
		if (cmd.w_dec && !sts.w_done) begin
			if (w_q < lsum_q) begin
				node_q <= left_n;
			end else if (w_q - lsum_q < SUM_W'(sw_rd)) begin
				node_q <= node_q;
			end else begin
				w_q <= w_q - lsum_q - SUM_W'(sw_rd);
				node_q <= left_n + NW'(1);
			end
		end
	end

	always_comb lsum_q = rd_left_q ? ss_rd : '0;

	logic right_out;
	always_comb begin
		right_out = (node_q > NW'((SLOTS - 1) / 2));
		sts.init_last = (init_q == NW'(SLOTS - 1));
		sts.full      = (free_head_q == '0) || (free_head_q > NW'(SLOTS));
		sts.del_bad   = (req_q.slot_index == '0) || (req_q.slot_index > IDX_W'(SLOTS)) ||
			!valid_q[req_q.slot_index[AW-1:0] - AW'(1)];
		sts.empty     = (total_q == '0);
		sts.p_last    = (node_q == NW'(1));
		sts.m_last    = (mcnt_q == 6'(RND_W - 1));
		sts.w_done    = !(w_q < lsum_q) &&
			((w_q - lsum_q < SUM_W'(sw_rd)) || right_out || node_bad);
		res.status       = st_q;
		res.chosen_slot  = IDX_W'(chosen_q);
		res.total_weight = total_q;
		res.occupancy    = IDX_W'(used_q);
	end
endmodule

// ----- rtl/wrst_ctrl.sv -----
// Weighted random select tree controller: sequences init sweep, alloc,
// delete and select over the datapath. Depends on wrst_pkg.
module wrst_ctrl import wrst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] func,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);
	state_t state_q, state_d;
	func_t  fn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			fn_q    <= FN_NONE;
		end else begin
			state_q <= state_d;
			if (start && !busy) fn_q <= func_t'(func);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (fn_q)
					FN_ALLOC: begin
						if (sts.full) begin
							cmd.finish_st = 1'b1; cmd.st = ST_FULL; state_d = S_DONE;
						end else begin
							cmd.a_rdnext = 1'b1; state_d = S_A_WAIT;
						end
					end
					FN_DELETE: begin
						if (sts.del_bad) begin
							cmd.finish_st = 1'b1; cmd.st = ST_BAD; state_d = S_DONE;
						end else begin
							cmd.d_rd = 1'b1; state_d = S_D_WAIT;
						end
					end
					FN_SELECT: begin
						if (sts.empty) begin
							cmd.finish_st = 1'b1; cmd.st = ST_EMPTY; state_d = S_DONE;
						end else begin
							state_d = S_M_STEP;
						end
					end
					default: begin
						cmd.finish_st = 1'b1; cmd.st = ST_BAD; state_d = S_DONE;
					end
				endcase
			end
			S_A_WAIT: begin
				cmd.a_rdnext = 1'b1; state_d = S_A_SETUP;
			end
			S_A_SETUP: begin
				cmd.a_setup = 1'b1; state_d = S_P_RD;
			end
			S_D_WAIT: begin
				cmd.d_rd = 1'b1; state_d = S_D_SETUP;
			end
			S_D_SETUP: begin
				cmd.d_setup = 1'b1; state_d = S_P_RD;
			end
			S_P_RD: begin
				cmd.p_rd = 1'b1; state_d = S_P_WAIT;
			end
			S_P_WAIT: begin
				cmd.p_rd = 1'b1; state_d = S_P_WR;
			end
			S_P_WR: begin
				cmd.p_wr = 1'b1;
				if (sts.p_last) begin
					cmd.finish_st = 1'b1; cmd.st = ST_OK; state_d = S_DONE;
				end else begin
					state_d = S_P_RD;
				end
			end
			S_M_STEP: begin
				cmd.m_step = 1'b1;
				if (sts.m_last) state_d = S_W_RD;
			end
			S_W_RD: begin
				cmd.w_rd = 1'b1; state_d = S_W_WAIT;
			end
			S_W_WAIT: begin
				cmd.w_rd = 1'b1; state_d = S_W_DEC;
			end
			S_W_DEC: begin
				cmd.w_dec = 1'b1;
				if (sts.w_done) begin
					cmd.finish_st = 1'b1; cmd.st = ST_OK; state_d = S_DONE;
				end else begin
					state_d = S_W_RD;
				end
			end
			S_DONE: begin
				done = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ----- rtl/weighted_random_select_tree_unit.sv -----
// Weighted random select tree, top level: controller plus datapath.
// Depends on wrst_pkg, wrst_ctrl, wrst_dp, wrst_ram.
//
// After reset the block sweeps its slot memories with busy high. An
// operation is taken when start is high and busy low; one result beat
// follows on result with done high for one cycle, and the receiver cannot
// stall it. Allocate and delete update the subtree sums on every tree
// level from the slot up to the root (up to log2(SLOTS)+1 levels); each
// level is one read-modify-write of the subtree-sum RAM. Select runs a
// bit-serial modulo of the random word by the total weight, then walks the
// tree from the root one level at a time. Full, empty, bad and unused
// operations go from dispatch straight to done.
module weighted_random_select_tree_unit import wrst_pkg::*; #(
	parameter int SLOTS = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_beat_t  cmd_in,
	output logic      done,
	output out_beat_t result
);
	cmd_t cmd;
	sts_t sts;

	wrst_ctrl u_ctrl (.clk, .arst_n, .start, .func(cmd_in.func), .sts, .cmd, .busy, .done);
	wrst_dp #(.SLOTS(SLOTS)) u_dp (.clk, .arst_n, .in_beat(cmd_in), .cmd, .sts,
		.res(result));
endmodule

// ----- rtl/wrst_chk.sv -----
// Port-level checker for the weighted random select tree, with its bind.
// Depends on wrst_pkg.
module wrst_chk import wrst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input logic      done,
	input out_beat_t result
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done twice");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after accept");
	a_zero_chosen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> result.chosen_slot == '0)
		else $error("slot on failure");
endmodule

bind weighted_random_select_tree_unit wrst_chk u_chk (.clk, .arst_n, .start, .busy,
	.done, .result);
